/* rtl/tds_pkg.sv */
// Shared types and constants for the tick-delay task scheduler.
// No dependencies.
package tds_pkg;

  localparam int MASK_W          = 8;
  localparam int DEF_TASK_SLOTS  = 8;
  localparam int DEF_DELAY_WIDTH = 32;
  localparam int TICKS_W         = 32;
  localparam int RUN_W           = 3;

  localparam logic [MASK_W-1:0] MASK_RESET = 8'h80;

  // action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_DELAY = 1'b1;

  typedef enum logic [1:0] {
    ST_ABSENT  = 2'd0,
    ST_READY   = 2'd1,
    ST_BLOCKED = 2'd2
  } slot_state_e;

  // data handed from one slot cell to the next
  typedef struct packed {
    logic              token;
    logic              found;
    logic [MASK_W-1:0] ready_mask;
    logic [MASK_W-1:0] woken_mask;
  } link_t;

endpackage

/* rtl/tds_cell.sv */
// One task slot of the scheduler chain: status, delay counter, selection step.
// Depends on tds_pkg.
module tds_cell import tds_pkg::*; #(
  parameter int IDX         = 0,
  parameter int SLOT_W      = 3,
  parameter int DELAY_WIDTH = DEF_DELAY_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [MASK_W-1:0]      mask_i,
  input  logic                   action_i,
  input  logic [DELAY_WIDTH-1:0] ticks_i,
  input  logic [SLOT_W-1:0]      cur_i,
  input  link_t                  link_i,
  output link_t                  link_o,
  output logic                   take_o
);

  localparam logic [MASK_W-1:0] OWN_BIT = MASK_W'(1) << IDX;

  slot_state_e            status_q, status_d;
  logic [DELAY_WIDTH-1:0] cnt_q, cnt_d;
  logic                   woke;
  logic                   is_cur;
  logic                   ready_now;
  link_t                  link_d;

  assign is_cur = (cur_i == SLOT_W'(IDX));

  always_comb begin
    status_d = status_q;
    cnt_d    = cnt_q;
    woke     = 1'b0;
    if (action_i == ACT_DELAY) begin
      if (is_cur && status_q != ST_ABSENT) begin
        status_d = ST_BLOCKED;
        cnt_d    = ticks_i;
      end
    end else if (status_q == ST_BLOCKED) begin
      if (cnt_q <= DELAY_WIDTH'(1)) begin
        status_d = ST_READY;
        cnt_d    = '0;
        woke     = 1'b1;
      end else begin
        cnt_d = cnt_q - DELAY_WIDTH'(1);
      end
    end
  end

  assign ready_now = (status_d == ST_READY);
  assign take_o    = link_i.token && !link_i.found && ready_now && !is_cur;

  always_comb begin
    link_d            = link_i;
    link_d.found      = link_i.found | take_o;
    link_d.ready_mask = link_i.ready_mask | (ready_now ? OWN_BIT : '0);
    link_d.woken_mask = link_i.woken_mask | (woke ? OWN_BIT : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= (|(MASK_RESET & OWN_BIT)) ? ST_READY : ST_ABSENT;
      cnt_q    <= '0;
      link_o   <= '0;
    end else begin
      link_o <= link_d;
      if (load_i) begin
        status_q <= (|(mask_i & OWN_BIT)) ? ST_READY : ST_ABSENT;
        cnt_q    <= '0;
      end else if (link_i.token) begin
        status_q <= status_d;
        cnt_q    <= cnt_d;
      end
    end
  end

endmodule

/* rtl/tick_delay_task_scheduler.sv */
// Top level of the tick-delay task scheduler: control, item registers, result output.
// Depends on tds_pkg and tds_cell.
//
// Usage:
//   Request channel (in_valid_i/in_ready_o): action_i = 0 is one system tick,
//   action_i = 1 blocks the running task for delay_ticks_i ticks (0 acts as 1,
//   values too wide for the counter saturate).
//   Result channel (out_valid_o/out_ready_i): one result per request with the
//   running slot, the ready slots and the slots this tick woke.
//   Config: cfg_we_i loads cfg_wdata_i as the present mask; every slot reloads
//   (present -> ready, else absent, counters cleared). Write only while idle.
// Timing:
//   A token walks the row of slot cells, one cell per cycle, through the
//   start register and the link register of each cell; the result then moves
//   into the output register. No new request is taken until the walk of the
//   previous one has ended and its result has left the pending register.
// Reset:
//   Slot 7 ready (mask 0x80), all others absent, running slot TASK_SLOTS-1,
//   no result pending.
// Stall:
//   If a result is still waiting when the next finishes, the new one is held
//   in a pending register and in_ready_o stays low until the output frees.
module tick_delay_task_scheduler import tds_pkg::*; #(
  parameter int TASK_SLOTS  = DEF_TASK_SLOTS,
  parameter int DELAY_WIDTH = DEF_DELAY_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MASK_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [TICKS_W-1:0] delay_ticks_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RUN_W-1:0]   running_task_o,
  output logic [MASK_W-1:0]  ready_mask_o,
  output logic [MASK_W-1:0]  woken_mask_o
);

  localparam int SLOT_W = $clog2(TASK_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_e;

  state_e                 state_q;
  logic                   start_q;
  logic                   act_q;
  logic [DELAY_WIDTH-1:0] ticks_q;
  logic [SLOT_W-1:0]      cur_q;
  logic [SLOT_W-1:0]      pick_q;
  logic                   out_valid_q;
  logic [RUN_W-1:0]       run_q, pend_run_q;
  logic [MASK_W-1:0]      rdy_q, pend_rdy_q;
  logic [MASK_W-1:0]      wok_q, pend_wok_q;

  logic                   in_fire;
  logic                   over;
  logic [DELAY_WIDTH-1:0] ticks_sat, ticks_fix;
  logic [TASK_SLOTS-1:0]  take;
  logic                   any_take;
  logic [SLOT_W-1:0]      take_idx;
  logic [SLOT_W-1:0]      cur_next;
  logic                   walk_done;
  logic                   out_free;
  logic                   out_load;
  link_t                  link [TASK_SLOTS+1];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // saturate to the counter width, zero delay wakes on the next tick
  assign over      = (DELAY_WIDTH < TICKS_W) && (|(delay_ticks_i >> DELAY_WIDTH));
  assign ticks_sat = over ? '1 : DELAY_WIDTH'(delay_ticks_i);
  assign ticks_fix = (ticks_sat == '0) ? DELAY_WIDTH'(1) : ticks_sat;

  // token enters the first cell the cycle after acceptance
  assign link[0] = '{token: start_q, found: 1'b0, ready_mask: '0, woken_mask: '0};

  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    tds_cell #(
      .IDX         (g),
      .SLOT_W      (SLOT_W),
      .DELAY_WIDTH (DELAY_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (cfg_we_i),
      .mask_i   (cfg_wdata_i),
      .action_i (act_q),
      .ticks_i  (ticks_q),
      .cur_i    (cur_q),
      .link_i   (link[g]),
      .link_o   (link[g+1]),
      .take_o   (take[g])
    );
  end

  // first ready non-running cell along the chain takes; at most one bit per cycle
  always_comb begin
    take_idx = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (take[i]) take_idx = SLOT_W'(i);
    end
  end
  assign any_take = |take;

  assign walk_done = (state_q == S_WALK) && link[TASK_SLOTS].token;
  assign cur_next  = link[TASK_SLOTS].found ? pick_q : cur_q;
  assign out_free  = !out_valid_q || out_ready_i;

  // a fresh or pending result moves into the output register
  assign out_load  = (walk_done && out_free) || ((state_q == S_HOLD) && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      cur_q       <= SLOT_W'(TASK_SLOTS - 1);
      out_valid_q <= 1'b0;
    end else begin
      start_q <= in_fire;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) state_q <= S_WALK;
        end
        S_WALK: begin
          if (walk_done) begin
            cur_q <= cur_next;
            if (out_free) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q   <= action_i;
      ticks_q <= ticks_fix;
      pick_q  <= cur_q;
    end else if (any_take) begin
      pick_q <= take_idx;
    end
    if (walk_done) begin
      if (out_free) begin
        run_q <= RUN_W'(cur_next);
        rdy_q <= link[TASK_SLOTS].ready_mask;
        wok_q <= link[TASK_SLOTS].woken_mask;
      end else begin
        pend_run_q <= RUN_W'(cur_next);
        pend_rdy_q <= link[TASK_SLOTS].ready_mask;
        pend_wok_q <= link[TASK_SLOTS].woken_mask;
      end
    end else if (state_q == S_HOLD && out_ready_i) begin
      run_q <= pend_run_q;
      rdy_q <= pend_rdy_q;
      wok_q <= pend_wok_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_task_o = run_q;
  assign ready_mask_o   = rdy_q;
  assign woken_mask_o   = wok_q;

  // a woken slot is always ready in the same result
  a_woken_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((woken_mask_o & ~ready_mask_o) == '0))
    else $error("woken slot not ready");

  // one slot at most is picked per cycle
  a_one_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(take))
    else $error("more than one slot picked");

  // a request is in flight after acceptance, so none is taken next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken during walk");

  // the token never reaches the end of the chain unless a walk is running
  a_token_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[TASK_SLOTS].token |-> (state_q == S_WALK))
    else $error("stray token");

endmodule

/* verif/tick_delay_task_scheduler_tb.sv */
// Self-checking testbench for tick_delay_task_scheduler: directed table, then random
// requests under several idling patterns, checked against an in-bench scheduler model.
// Depends on tds_pkg and the scheduler RTL.
module tick_delay_task_scheduler_tb;
  import tds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = DEF_TASK_SLOTS;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 191;
  localparam int HOLD_CYC   = 250;   // long receiver hold-off
  localparam int DRAIN_CYC  = SLOTS + 6;

  // one result of the scheduler
  typedef struct packed {
    logic [RUN_W-1:0]  run;
    logic [MASK_W-1:0] ready;
    logic [MASK_W-1:0] woken;
  } sched_res_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // directed row: a request or a mask write; res is used only when typed is set
  typedef struct {
    row_kind_e          kind;
    logic               act;
    logic [TICKS_W-1:0] ticks;
    logic [MASK_W-1:0]  mask;
    bit                 typed;
    sched_res_t         res;
  } dir_row_t;

  localparam int DIR_N = 24;

  // Directed walk. Starts from reset: only slot 7 present, slot 7 running.
  dir_row_t dir_rows [DIR_N] = '{
    // idle task alone: tick leaves it running
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b1, '{3'd7, 8'h80, 8'h00}},
    // zero delay is stored as one tick
    '{ROW_REQ, ACT_DELAY, 32'd0,          8'h00, 1'b1, '{3'd7, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b1, '{3'd7, 8'h80, 8'h80}},
    // largest delay, then reload while already blocked
    '{ROW_REQ, ACT_DELAY, 32'hFFFF_FFFF,  8'h00, 1'b1, '{3'd7, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_DELAY, 32'd3,          8'h00, 1'b1, '{3'd7, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b1, '{3'd7, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b1, '{3'd7, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b1, '{3'd7, 8'h80, 8'h80}},
    // empty table: delay of an absent running slot changes nothing
    '{ROW_CFG, ACT_TICK,  32'd0,          8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_DELAY, 32'd5,          8'h00, 1'b1, '{3'd7, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b1, '{3'd7, 8'h00, 8'h00}},
    // full table: running slot kept across the write, lowest other slot wins
    '{ROW_CFG, ACT_TICK,  32'd0,          8'hFF, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b1, '{3'd0, 8'hFF, 8'h00}},
    '{ROW_REQ, ACT_DELAY, 32'hFFFF_FFFF,  8'h00, 1'b1, '{3'd1, 8'hFE, 8'h00}},
    '{ROW_REQ, ACT_DELAY, 32'd2,          8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_DELAY, 32'd1,          8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_DELAY, 32'h8000_0000,  8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_DELAY, 32'h7FFF_FFFF,  8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    // single low slot
    '{ROW_CFG, ACT_TICK,  32'd0,          8'h01, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_DELAY, 32'd0,          8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}},
    '{ROW_REQ, ACT_TICK,  32'd0,          8'h00, 1'b0, '{3'd0, 8'h00, 8'h00}}
  };

  // DUT connections; all inputs known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [MASK_W-1:0]  cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               action        = ACT_TICK;
  logic [TICKS_W-1:0] delay_ticks   = '0;
  logic               out_ready     = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [RUN_W-1:0]   running_task;
  logic [MASK_W-1:0]  ready_mask;
  logic [MASK_W-1:0]  woken_mask;

  tick_delay_task_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .delay_ticks_i  (delay_ticks),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .running_task_o (running_task),
    .ready_mask_o   (ready_mask),
    .woken_mask_o   (woken_mask)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("[tick_delay_task_scheduler] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scheduler model: slot table, delay counters, running slot.
  // Counters are as wide as delay_ticks here, so no saturation is needed.
  // ---------------------------------------------------------------------------
  slot_state_e        slot_st  [SLOTS];
  logic [TICKS_W-1:0] slot_cnt [SLOTS];
  logic [RUN_W-1:0]   run_slot;

  sched_res_t         sched_q [$];   // expected scheduler results, oldest first

  int fail_cnt   = 0;
  int n_tick     = 0;
  int n_delay    = 0;
  int n_results  = 0;
  int n_wakes    = 0;
  int n_masks    = 0;

  // Present slots become ready, the rest absent; counters cleared.
  function automatic void reload_table(input logic [MASK_W-1:0] mask);
    for (int i = 0; i < SLOTS; i++) begin
      slot_st[i]  = mask[i] ? ST_READY : ST_ABSENT;
      slot_cnt[i] = '0;
    end
  endfunction

  function automatic sched_res_t sched_step(input logic act, input logic [TICKS_W-1:0] ticks);
    sched_res_t r;
    bit         found;
    r     = '0;
    found = 1'b0;
    if (act == ACT_DELAY) begin
      if (slot_st[run_slot] != ST_ABSENT) begin
        slot_cnt[run_slot] = (ticks == '0) ? TICKS_W'(1) : ticks;
        slot_st[run_slot]  = ST_BLOCKED;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_st[i] == ST_BLOCKED) begin
          if (slot_cnt[i] <= TICKS_W'(1)) begin
            slot_cnt[i] = '0;
            slot_st[i]  = ST_READY;
            r.woken[i]  = 1'b1;
          end else begin
            slot_cnt[i] = slot_cnt[i] - 1'b1;
          end
        end
      end
    end
    // lowest ready slot other than the running one; else keep running slot
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && i != run_slot && slot_st[i] == ST_READY) begin
        run_slot = RUN_W'(i);
        found    = 1'b1;
      end
    end
    for (int i = 0; i < SLOTS; i++) r.ready[i] = (slot_st[i] == ST_READY);
    r.run = run_slot;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. send_req raises valid and returns at the accepting edge with
  // valid still high; the caller lowers it only when it idles.
  // ---------------------------------------------------------------------------
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;

  task automatic send_req(input logic act, input logic [TICKS_W-1:0] ticks,
                          input bit typed, input sched_res_t typed_res);
    sched_res_t pred;
    in_valid    <= 1'b1;
    action      <= act;
    delay_ticks <= ticks;
    do @(posedge clk_i); while (!in_ready);
    pred = sched_step(act, ticks);
    sched_q.push_back(typed ? typed_res : pred);
    if (act == ACT_DELAY) n_delay++;
    else n_tick++;
  endtask

  // Sender gap: idle cycles drawn per cycle from tx_gap_pct.
  task automatic tx_gap();
    if ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_gap_pct);
    end
  endtask

  // Mask write only once every outstanding request has produced its result.
  task automatic write_mask(input logic [MASK_W-1:0] mask);
    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    reload_table(mask);
    n_masks++;
  endtask

  // Mostly short delays so slots keep cycling; some huge ones and both extremes.
  function automatic logic [TICKS_W-1:0] rand_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 55) return TICKS_W'($urandom_range(6));
    if (r < 80) return TICKS_W'($urandom_range(40));
    if (r < 90) return TICKS_W'($urandom);
    if (r < 95) return '1;
    return '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus one long hold-off, counted here.
  // ---------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    sched_res_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (sched_q.size() == 0) begin
        $error("result with no request outstanding: run %0d ready %02h woken %02h",
               running_task, ready_mask, woken_mask);
        fail_cnt++;
      end else begin
        want = sched_q.pop_front();
        n_results++;
        if (woken_mask != '0) n_wakes++;
        if (running_task !== want.run) begin
          $error("running_task: expected %0d, got %0d", want.run, running_task);
          fail_cnt++;
        end
        if (ready_mask !== want.ready) begin
          $error("ready_mask: expected %02h, got %02h", want.ready, ready_mask);
          fail_cnt++;
        end
        if (woken_mask !== want.woken) begin
          $error("woken_mask: expected %02h, got %02h", want.woken, woken_mask);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [MASK_W-1:0] mask;
    logic              act;
    reload_table(MASK_RESET);
    run_slot = RUN_W'(SLOTS - 1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, back-to-back requests, receiver always ready
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_mask(dir_rows[i].mask);
      else send_req(dir_rows[i].act, dir_rows[i].ticks, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases: idling pattern rotates, mask changes every phase
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 65; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 65; end
        default: begin tx_gap_pct = 29; rx_stall_pct = 29; end
      endcase
      case (p)
        0: mask = 8'hFF;
        1: mask = 8'h00;
        6: mask = 8'h81;
        default: mask = MASK_W'($urandom_range(255));
      endcase
      write_mask(mask);
      for (int k = 0; k < PHASE_REQS; k++) begin
        // receiver freezes mid-phase while requests keep coming: fills the pipe
        if (p == 0 && k == PHASE_REQS / 2) hold_req <= hold_req + 1;
        tx_gap();
        act = ($urandom_range(99) < 60) ? ACT_TICK : ACT_DELAY;
        send_req(act, (act == ACT_DELAY) ? rand_ticks() : TICKS_W'($urandom),
                 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Covered %0d ticks and %0d delays over %0d mask settings;",
             n_tick, n_delay, n_masks);
    $display("%0d results checked, %0d of them waking slots, %0d mismatches.",
             n_results, n_wakes, fail_cnt);
    if (fail_cnt == 0) begin
      $display("[tick_delay_task_scheduler] OK");
    end else begin
      $display("[tick_delay_task_scheduler] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tds_pkg.sv
rtl/tds_cell.sv
rtl/tick_delay_task_scheduler.sv
verif/tick_delay_task_scheduler_tb.sv
